FILE: rtl/core/cip_pkg.sv
package cip_pkg;

    // Accumulator width; the sums saturate at 2^SUM_BITS - 1.
    localparam int SUM_BITS = 24;
    localparam int OUT_W    = 24;

    localparam int PT_W    = 16;
    localparam int ETA_W   = 13;
    localparam int PHI_W   = 12;
    localparam int ANG_W   = 12;
    localparam int D2_W    = 27;
    localparam int CFG_W   = 16;

    // Item kinds.
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_CAND  = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_THR = 2'd0;
    localparam logic [1:0] CFG_VETO = 2'd1;
    localparam logic [1:0] CFG_ACT  = 2'd2;

    localparam logic [PT_W-1:0] ACT_RADIUS_RST = 16'd261;

    // Mini cone constants, pt in 1/16 GeV, angles in pi/2048 units.
    localparam logic [PT_W-1:0] MINI_P_LOW    = 16'd800;
    localparam logic [PT_W-1:0] MINI_P_HIGH   = 16'd3200;
    localparam logic [D2_W-1:0] MINI_D2_WIDE   = 27'd16900;
    localparam logic [D2_W-1:0] MINI_D2_NARROW = 27'd1089;
    localparam logic [38:0]     MINI_K         = 39'd10879324416;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_ISO,
        OP_ACT,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op             op;
        logic [PT_W-1:0] pt;
    } t_cmd;

    typedef struct packed {
        logic [PT_W-1:0]  thr;
        logic [ANG_W-1:0] veto_r;
        logic [ANG_W-1:0] act_r;
    } t_cfg;

    typedef struct packed {
        logic       full;
        logic       empty;
    } t_q_ctl;

endpackage

FILE: rtl/core/cip_front.sv
module cip_front
    import cip_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [1:0]       i_kind,
    input  logic [PT_W-1:0]  i_pt,
    input  logic [ETA_W-1:0] i_eta,
    input  logic [PHI_W-1:0] i_phi,
    input  logic             i_q_full,
    output logic             o_push,
    output t_cmd             o_cmd
);

    typedef struct packed {
        logic [1:0]      kind;
        logic [PT_W-1:0] pt;
        logic [PT_W-1:0] ppt;
        logic            thr_ok;
    } t_item;

    logic [PT_W-1:0]  r_probe_pt;
    logic [ETA_W-1:0] r_probe_eta;
    logic [PHI_W-1:0] r_probe_phi;

    logic [23:0] r_act2;
    logic [23:0] r_veto2;

    logic r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid;
    t_item r_s1, r_s2, r_s3, r_s4;

    logic [ETA_W-1:0] r_s1_ade;
    logic [ANG_W-1:0] r_s1_dp;
    logic [25:0]      r_s2_ade2;
    logic [23:0]      r_s2_dp2;
    logic [D2_W-1:0]  r_s3_d2;

    logic        r_s4_drop;
    logic        r_s4_wide, r_s4_narrow, r_s4_wide_in, r_s4_narrow_in, r_s4_small;
    logic [26:0] r_s4_q;
    logic [11:0] r_s4_p;

    logic             en;
    logic             acc;
    logic signed [13:0] de;
    logic [13:0]      de_abs;
    logic [ANG_W-1:0] dp_raw;
    logic [ANG_W-1:0] dp_fold;
    logic [38:0]      mid_prod;
    logic             in_mini;
    logic             s4_needs;

    always_ff @(posedge i_clk) begin
        r_act2  <= 24'(i_cfg.act_r) * 24'(i_cfg.act_r);
        r_veto2 <= 24'(i_cfg.veto_r) * 24'(i_cfg.veto_r);
    end

    // Only items that change the sums or emit take a queue slot.
    always_comb begin
        s4_needs = 1'b0;
        case (r_s4.kind)
            KIND_START, KIND_END: s4_needs = 1'b1;
            KIND_CAND:            s4_needs = !r_s4_drop;
            default:              s4_needs = 1'b0;
        endcase
    end

    assign en      = !(r_s4_valid && s4_needs && i_q_full);
    assign o_ready = en;
    assign acc     = i_valid && en;

    always_comb begin
        de      = $signed({i_eta[ETA_W-1], i_eta})
                  - $signed({r_probe_eta[ETA_W-1], r_probe_eta});
        de_abs  = de[13] ? 14'(-de) : 14'(de);
        dp_raw  = i_phi - r_probe_phi;
        dp_fold = (dp_raw > 12'd2048) ? (~dp_raw) + 12'd1 : dp_raw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe_pt  <= '0;
            r_probe_eta <= '0;
            r_probe_phi <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
        end else begin
            if (acc && i_kind == KIND_START) begin
                r_probe_pt  <= i_pt;
                r_probe_eta <= i_eta;
                r_probe_phi <= i_phi;
            end
            if (en) begin
                r_s1_valid <= acc;
                r_s2_valid <= r_s1_valid;
                r_s3_valid <= r_s2_valid;
                r_s4_valid <= r_s3_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1.kind   <= i_kind;
            r_s1.pt     <= i_pt;
            r_s1.ppt    <= r_probe_pt;
            r_s1.thr_ok <= (i_pt >= i_cfg.thr);
            r_s1_ade    <= de_abs[ETA_W-1:0];
            r_s1_dp     <= dp_fold;

            r_s2      <= r_s1;
            r_s2_ade2 <= 26'(r_s1_ade) * 26'(r_s1_ade);
            r_s2_dp2  <= 24'(r_s1_dp) * 24'(r_s1_dp);

            r_s3    <= r_s2;
            r_s3_d2 <= D2_W'(r_s2_ade2) + D2_W'(r_s2_dp2);

            r_s4           <= r_s3;
            r_s4_drop      <= !r_s3.thr_ok || (r_s3_d2 > D2_W'(r_act2))
                              || (r_s3_d2 < D2_W'(r_veto2));
            r_s4_wide      <= (r_s3.ppt <= MINI_P_LOW);
            r_s4_narrow    <= (r_s3.ppt >= MINI_P_HIGH);
            r_s4_wide_in   <= (r_s3_d2 <= MINI_D2_WIDE);
            r_s4_narrow_in <= (r_s3_d2 <= MINI_D2_NARROW);
            // Above 2^15 the candidate is outside the cone for any mid-range probe pt.
            r_s4_small     <= (r_s3_d2[D2_W-1:15] == '0);
            r_s4_q         <= 27'(r_s3_d2[14:0]) * 27'(r_s3.ppt[11:0]);
            r_s4_p         <= r_s3.ppt[11:0];
        end
    end

    always_comb begin
        mid_prod = 39'(r_s4_q) * 39'(r_s4_p);
        if (r_s4_wide) begin
            in_mini = r_s4_wide_in;
        end else if (r_s4_narrow) begin
            in_mini = r_s4_narrow_in;
        end else begin
            in_mini = r_s4_small && (mid_prod <= MINI_K);
        end
    end

    always_comb begin
        o_cmd.pt = r_s4.pt;
        case (r_s4.kind)
            KIND_START: o_cmd.op = OP_CLEAR;
            KIND_END:   o_cmd.op = OP_EMIT;
            default:    o_cmd.op = in_mini ? OP_ISO : OP_ACT;
        endcase
        o_push = r_s4_valid && s4_needs && !i_q_full;
    end

endmodule

FILE: rtl/core/cip_queue.sv
module cip_queue
    import cip_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_cmd   i_cmd,
    input  logic   i_pop,
    output t_cmd   o_cmd,
    output t_q_ctl o_ctl
);

    t_cmd           r_mem [QDEPTH];
    logic [QAW-1:0] r_wr_ptr;
    logic [QAW-1:0] r_rd_ptr;
    logic [QAW:0]   r_count;

    logic full, empty, do_push, do_pop;

    assign full    = (r_count == (QAW+1)'(QDEPTH));
    assign empty   = (r_count == '0);
    assign do_push = i_push && !full;
    assign do_pop  = i_pop && !empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        o_ctl.full  = full;
        o_ctl.empty = empty;
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/core/cip_back.sv
module cip_back
    import cip_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic             i_cmd_valid,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [OUT_W-1:0] o_iso_sum,
    output logic [OUT_W-1:0] o_activity_sum
);

    logic [SUM_BITS-1:0] r_iso_acc;
    logic [SUM_BITS-1:0] r_act_acc;
    logic                r_out_valid;
    logic [OUT_W-1:0]    r_out_iso;
    logic [OUT_W-1:0]    r_out_act;

    logic                out_free;
    logic [SUM_BITS:0]   iso_s;
    logic [SUM_BITS:0]   act_s;
    logic [SUM_BITS-1:0] iso_sat;
    logic [SUM_BITS-1:0] act_sat;

    assign out_free = !r_out_valid || i_ready;
    assign o_pop    = i_cmd_valid && ((i_cmd.op != OP_EMIT) || out_free);

    always_comb begin
        iso_s   = {1'b0, r_iso_acc} + (SUM_BITS+1)'(i_cmd.pt);
        act_s   = {1'b0, r_act_acc} + (SUM_BITS+1)'(i_cmd.pt);
        iso_sat = iso_s[SUM_BITS] ? '1 : iso_s[SUM_BITS-1:0];
        act_sat = act_s[SUM_BITS] ? '1 : act_s[SUM_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iso_acc   <= '0;
            r_act_acc   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop && i_cmd.op == OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                unique case (i_cmd.op)
                    OP_CLEAR: begin
                        r_iso_acc <= '0;
                        r_act_acc <= '0;
                    end
                    OP_ISO:  r_iso_acc <= iso_sat;
                    OP_ACT:  r_act_acc <= act_sat;
                    OP_EMIT: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.op == OP_EMIT) begin
            r_out_iso <= OUT_W'(r_iso_acc);
            r_out_act <= OUT_W'(r_act_acc);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_iso_sum      = r_out_iso;
    assign o_activity_sum = r_out_act;

endmodule

FILE: rtl/core/cone_isolation_pt_sum.sv
// Channel   Direction  Handshake                Payload
// input     in         i_in_valid / o_in_ready  i_kind, i_pt, i_eta, i_phi
// result    out        o_out_valid / i_out_ready o_iso_sum, o_activity_sum
// config    in         i_cfg_wr_en              i_cfg_index, i_cfg_data
//
// One item is taken per cycle while the command queue has room. An end item
// passes through the four front stages (angle differences, squares, squared
// distance, cone tests) and the queue, and its result lands in the output
// register. Reset is synchronous and active low; it clears the probe, both
// sums, the queue and all valid flags. A stalled result only holds back the
// queue, so the front keeps taking items until the queue fills.
module cone_isolation_pt_sum
    import cip_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [1:0]       i_kind,
    input  logic [PT_W-1:0]  i_pt,
    input  logic [ETA_W-1:0] i_eta,
    input  logic [PHI_W-1:0] i_phi,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [OUT_W-1:0] o_iso_sum,
    output logic [OUT_W-1:0] o_activity_sum,
    input  logic             i_cfg_wr_en,
    input  logic [1:0]       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);

    // Configuration registers. Writes to an unused index are ignored.
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.thr    <= '0;
            r_cfg.veto_r <= '0;
            r_cfg.act_r  <= ANG_W'(ACT_RADIUS_RST);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_THR:  r_cfg.thr    <= i_cfg_data;
                CFG_VETO: r_cfg.veto_r <= i_cfg_data[ANG_W-1:0];
                CFG_ACT:  r_cfg.act_r  <= i_cfg_data[ANG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The front classifies each item against the latched probe and turns it
    // into a command for the back: clear, add to one of the sums, or emit.
    logic   push;
    t_cmd   push_cmd;
    t_cmd   head_cmd;
    logic   pop;
    t_q_ctl q_ctl;

    cip_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_kind   (i_kind),
        .i_pt     (i_pt),
        .i_eta    (i_eta),
        .i_phi    (i_phi),
        .i_q_full (q_ctl.full),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    cip_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_ctl   (q_ctl)
    );

    // The back owns the saturating sums and the output register.
    cip_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (head_cmd),
        .i_cmd_valid    (!q_ctl.empty),
        .o_pop          (pop),
        .o_valid        (o_out_valid),
        .i_ready        (i_out_ready),
        .o_iso_sum      (o_iso_sum),
        .o_activity_sum (o_activity_sum)
    );

endmodule

FILE: tb/cone_isolation_pt_sum_test.sv
`timescale 1ns / 100ps

module cone_isolation_pt_sum_test;
    import cip_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 11;
    // A candidate can still be in flight in the result path when the last expected
    // sum pair has come out, so keep clocking after that before the next phase.
    localparam int DRAIN_CYCLES = 16;
    localparam int RUN_LIMIT_NS = 30_000_000;
    localparam int PHASE_COUNT  = 9;

    // Codes the package leaves unnamed: the spare item kind and the spare register slot.
    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam logic [1:0] CFG_SPARE  = 2'd3;

    // Mini cone: 0.2 rad up to 50 GeV, 10 GeV*rad / pt in between, 0.05 rad from 200 GeV.
    localparam longint unsigned WIDE_CONE_PT   = 800;
    localparam longint unsigned NARROW_CONE_PT = 3200;
    localparam longint unsigned WIDE_CONE_R    = 130;
    localparam longint unsigned NARROW_CONE_R  = 33;
    localparam longint unsigned MID_CONE_K     = 64'd104304 * 64'd104304;
    localparam longint unsigned SUM_CAP        = (64'd1 << SUM_BITS) - 1;

    typedef struct {
        logic [1:0]       kind;
        logic [PT_W-1:0]  pt;
        logic [ETA_W-1:0] eta;
        logic [PHI_W-1:0] phi;
    } t_track_item;

    typedef struct {
        logic [OUT_W-1:0] iso;
        logic [OUT_W-1:0] activity;
    } t_sum_pair;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_ready;
    logic [1:0]       i_kind;
    logic [PT_W-1:0]  i_pt;
    logic [ETA_W-1:0] i_eta;
    logic [PHI_W-1:0] i_phi;
    logic             o_out_valid;
    logic             i_out_ready;
    logic [OUT_W-1:0] o_iso_sum;
    logic [OUT_W-1:0] o_activity_sum;
    logic             i_cfg_wr_en;
    logic [1:0]       i_cfg_index;
    logic [CFG_W-1:0] i_cfg_data;

    cone_isolation_pt_sum dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_pt           (i_pt),
        .i_eta          (i_eta),
        .i_phi          (i_phi),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_iso_sum      (o_iso_sum),
        .o_activity_sum (o_activity_sum),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #HALF_PERIOD i_clk = ~i_clk;

    // Shadow copies of the configuration registers, updated when they are written.
    logic [PT_W-1:0]  thr_reg  = '0;
    logic [ANG_W-1:0] veto_reg = '0;
    logic [ANG_W-1:0] act_reg  = 12'd261;

    // Predicted probe and the two running sums, kept wide so saturation is explicit.
    logic [PT_W-1:0]  probe_pt  = '0;
    logic [ETA_W-1:0] probe_eta = '0;
    logic [PHI_W-1:0] probe_phi = '0;
    longint unsigned  iso_total = 0;
    longint unsigned  act_total = 0;

    t_track_item item_q[$];         // items waiting for the input driver
    t_sum_pair   pending_sums[$];   // predicted sum pairs not yet seen on the output

    int  items_queued    = 0;
    int  items_taken     = 0;
    int  results_checked = 0;
    int  mismatches      = 0;
    int  iso_hits        = 0;
    int  act_hits        = 0;
    bit  in_taken        = 1'b0;
    int  send_gap        = 0;
    int  recv_gap        = 0;
    int  hold_request    = 0;
    int  hold_left       = 0;
    bit  send_quiet      = 1'b0;
    bit  recv_quiet      = 1'b0;

    // Generator's own view of the current probe, used to place candidates near it.
    logic [ETA_W-1:0] gen_probe_eta = '0;
    logic [PHI_W-1:0] gen_probe_phi = '0;

    // Idle length between items or between ready pulses: mostly none or short,
    // now and then a long one. A quiet side never idles.
    function automatic int pick_gap(bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic bit in_mini_cone(longint unsigned d2, logic [PT_W-1:0] p);
        longint unsigned pw;
        pw = p;
        if (pw <= WIDE_CONE_PT)
            return d2 <= WIDE_CONE_R * WIDE_CONE_R;
        if (pw >= NARROW_CONE_PT)
            return d2 <= NARROW_CONE_R * NARROW_CONE_R;
        // Between the two fixed radii the cone shrinks as 1/pt, so scale by pt^2.
        return d2 * pw * pw <= MID_CONE_K;
    endfunction

    function automatic longint unsigned add_capped(longint unsigned acc, logic [PT_W-1:0] p);
        longint unsigned s;
        s = acc + p;
        return (s > SUM_CAP) ? SUM_CAP : s;
    endfunction

    // Apply one accepted item to the predicted probe and sums. An end item queues
    // the sum pair it should produce.
    function automatic void update_cone_sums(logic [1:0] kind, logic [PT_W-1:0] pt,
                                             logic [ETA_W-1:0] eta, logic [PHI_W-1:0] phi);
        int               de;
        int unsigned      ade;
        int unsigned      dp;
        logic [PHI_W-1:0] dwrap;
        longint unsigned  d2;
        t_sum_pair        pair;
        case (kind)
            KIND_START: begin
                probe_pt  = pt;
                probe_eta = eta;
                probe_phi = phi;
                iso_total = 0;
                act_total = 0;
            end
            KIND_END: begin
                pair.iso      = iso_total[OUT_W-1:0];
                pair.activity = act_total[OUT_W-1:0];
                pending_sums.push_back(pair);
            end
            KIND_CAND: begin
                if (pt >= thr_reg) begin
                    de    = $signed(eta) - $signed(probe_eta);
                    ade   = (de < 0) ? -de : de;
                    // Phi wraps around the full turn, so fold the difference to half a turn.
                    dwrap = phi - probe_phi;
                    dp    = (dwrap > 12'd2048) ? 4096 - dwrap : dwrap;
                    d2    = longint'(ade) * ade + longint'(dp) * dp;
                    if (d2 <= longint'(act_reg) * act_reg
                            && d2 >= longint'(veto_reg) * veto_reg) begin
                        if (in_mini_cone(d2, probe_pt)) begin
                            iso_total = add_capped(iso_total, pt);
                            iso_hits++;
                        end else begin
                            act_total = add_capped(act_total, pt);
                            act_hits++;
                        end
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Rising edge: take note of accepted items and check every result that leaves.
    always @(posedge i_clk) begin : watch_ports
        t_sum_pair want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                update_cone_sums(i_kind, i_pt, i_eta, i_phi);
                items_taken++;
                in_taken = 1'b1;
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_sums.size() == 0) begin
                    $display("%0t: unexpected result iso %0d activity %0d",
                             $time, o_iso_sum, o_activity_sum);
                    mismatches++;
                end else begin
                    want = pending_sums.pop_front();
                    if (o_iso_sum !== want.iso) begin
                        $display("%0t: iso_sum expected %0d, got %0d",
                                 $time, want.iso, o_iso_sum);
                    end
                    if (o_activity_sum !== want.activity) begin
                        $display("%0t: activity_sum expected %0d, got %0d",
                                 $time, want.activity, o_activity_sum);
                    end
                    if (o_iso_sum !== want.iso || o_activity_sum !== want.activity)
                        mismatches++;
                    results_checked++;
                end
            end
        end
    end

    // Falling edge: the sender. Valid is computed once per edge so it is never
    // dropped and raised again within one step.
    always @(negedge i_clk) begin : drive_items
        logic        offer;
        t_track_item it;
        if (i_rst_n) begin
            offer = i_in_valid;
            if (in_taken) begin
                in_taken = 1'b0;
                offer    = 1'b0;
            end
            if (!offer) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (item_q.size() > 0) begin
                    it = item_q.pop_front();
                    i_kind   <= it.kind;
                    i_pt     <= it.pt;
                    i_eta    <= it.eta;
                    i_phi    <= it.phi;
                    offer    = 1'b1;
                    send_gap = pick_gap(send_quiet);
                end
            end
            i_in_valid <= offer;
        end
    end

    // Falling edge: the receiver. A hold-off request from the stimulus is counted
    // down here, and the output stays blocked until the count runs out.
    always @(negedge i_clk) begin : drive_ready
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                recv_gap = pick_gap(recv_quiet);
            end
        end
    end

    task automatic queue_item(logic [1:0] kind, int pt, int eta, int phi);
        t_track_item it;
        it.kind = kind;
        it.pt   = pt[PT_W-1:0];
        it.eta  = eta[ETA_W-1:0];
        it.phi  = phi[PHI_W-1:0];
        item_q.push_back(it);
        items_queued++;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            CFG_THR:  thr_reg  = val;
            CFG_VETO: veto_reg = val[ANG_W-1:0];
            CFG_ACT:  act_reg  = val[ANG_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Block until every queued item is in, every predicted result is out, and the
    // pipeline has had time to finish any candidate behind the last end item.
    task automatic wait_idle();
        while (items_taken != items_queued || pending_sums.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // New probe: pt spread over the wide, sliding and narrow cone regions, eta
    // mostly inside the detector range.
    task automatic new_probe();
        int pt;
        int eta;
        case ($urandom_range(0, 3))
            0:       pt = $urandom_range(0, 800);
            1:       pt = $urandom_range(801, 3199);
            2:       pt = $urandom_range(3200, 65535);
            default: pt = $urandom_range(0, 65535);
        endcase
        if ($urandom_range(0, 9) == 0)
            eta = $urandom_range(0, 8191);
        else
            eta = int'($urandom_range(0, 6520)) - 3260;
        gen_probe_eta = eta[ETA_W-1:0];
        gen_probe_phi = PHI_W'($urandom_range(0, 4095));
        queue_item(KIND_START, pt, eta, int'(gen_probe_phi));
    endtask

    // Candidate placed around the current probe at one of several distance scales,
    // so the veto, mini and activity boundaries are all crossed.
    task automatic near_candidate();
        int span;
        int de;
        int dphi;
        int pt;
        int hi;
        case ($urandom_range(0, 3))
            0:       span = 40;
            1:       span = 160;
            2:       span = act_reg + 40;
            default: span = 2100;
        endcase
        de   = int'($urandom_range(0, 2 * span)) - span;
        dphi = int'($urandom_range(0, 2 * span)) - span;
        hi   = (thr_reg + 4000 > 65535) ? 65535 : thr_reg + 4000;
        if (thr_reg > 0 && $urandom_range(0, 99) < 15)
            pt = $urandom_range(0, thr_reg - 1);
        else if ($urandom_range(0, 1) == 0)
            pt = $urandom_range(thr_reg, hi);
        else
            pt = $urandom_range(thr_reg, 65535);
        queue_item(KIND_CAND, pt, int'(gen_probe_eta) + de, int'(gen_probe_phi) + dphi);
    endtask

    // Mostly complete probe / candidates / end sequences; the rest is stray
    // candidates, repeated ends, lone starts and spare-kind items.
    task automatic random_items(int count);
        int done;
        int n;
        int r;
        done = 0;
        while (done < count) begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
                n = $urandom_range(1, 12);
                new_probe();
                repeat (n) near_candidate();
                queue_item(KIND_END, $urandom_range(0, 65535), $urandom_range(0, 8191),
                           $urandom_range(0, 4095));
                done += n + 2;
            end else if (r < 88) begin
                n = $urandom_range(1, 4);
                repeat (n) near_candidate();
                done += n;
            end else if (r < 93) begin
                queue_item(KIND_END, 0, 0, 0);
                done++;
            end else if (r < 96) begin
                queue_item(KIND_SPARE, $urandom_range(0, 65535), $urandom_range(0, 8191),
                           $urandom_range(0, 4095));
            end else begin
                new_probe();
                done++;
            end
        end
    endtask

    // Drive one sum into saturation: a probe with the narrow cone and a long run of
    // full-scale candidates, either on top of it or just outside its mini cone.
    task automatic saturating_run(bit to_iso);
        queue_item(KIND_START, 4000, 0, 100);
        repeat (150) queue_item(KIND_CAND, 65535, 0, to_iso ? 100 : 200);
        queue_item(KIND_END, 0, 0, 0);
        repeat (150) queue_item(KIND_CAND, 65535, 0, to_iso ? 100 : 200);
        queue_item(KIND_END, 0, 0, 0);
    endtask

    // Short directed opener on the reset configuration (threshold 0, no veto cone,
    // activity radius 261).
    task automatic directed_items();
        // Candidates against the reset probe, which sits at the origin with pt zero.
        queue_item(KIND_CAND, 1, 0, 5);
        queue_item(KIND_CAND, 65535, 0, 200);
        queue_item(KIND_END, 0, 0, 0);
        // The spare kind with every payload bit set must leave everything alone.
        queue_item(KIND_SPARE, 65535, -1, 4095);
        // Probe at the negative eta edge and near the top of phi: the first
        // candidate is close only through the phi wrap.
        queue_item(KIND_START, 0, -3260, 4090);
        queue_item(KIND_CAND, 0, -3260, 10);
        queue_item(KIND_CAND, 100, 3260, 4090);
        queue_item(KIND_CAND, 7, -4096, 4090);
        queue_item(KIND_CAND, 65535, -3200, 4090);
        queue_item(KIND_END, 0, 0, 0);
        // A second end repeats the sums, and a candidate after it still counts.
        queue_item(KIND_END, 65535, 4095, 4095);
        queue_item(KIND_CAND, 9, -3260, 4090);
        queue_item(KIND_END, 0, 0, 0);
        // Narrow cone edge at 33 units and the activity edge at exactly 261.
        queue_item(KIND_START, 3200, 3260, 0);
        queue_item(KIND_CAND, 10, 3260, 33);
        queue_item(KIND_CAND, 20, 3260, 34);
        queue_item(KIND_CAND, 40, 3260, 3835);
        queue_item(KIND_CAND, 80, 3260, 3834);
        queue_item(KIND_END, 0, 0, 0);
        // Sliding cone just above 50 GeV, with eta at its positive 13-bit limit.
        queue_item(KIND_START, 801, 4095, 2048);
        queue_item(KIND_CAND, 3, 3965, 2048);
        queue_item(KIND_CAND, 5, 4095, 2179);
        queue_item(KIND_CAND, 6, 4095, 0);
        queue_item(KIND_END, 0, 0, 0);
    endtask

    initial begin : run_phases
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_kind      = KIND_START;
        i_pt        = '0;
        i_eta       = '0;
        i_phi       = '0;
        i_out_ready = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = CFG_THR;
        i_cfg_data  = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            send_quiet = ($urandom_range(0, 3) == 0);
            recv_quiet = ($urandom_range(0, 3) == 0);
            case (ph)
                0: directed_items();
                1: begin
                    // Widest acceptance; the write also sets bits above the register width.
                    write_reg(CFG_THR, 16'd0);
                    write_reg(CFG_VETO, 16'd0);
                    write_reg(CFG_ACT, 16'hFFFF);
                    send_quiet = 1'b1;
                    recv_quiet = 1'b1;
                    random_items(250);
                end
                2: begin
                    // Output blocked for a long stretch while the sender keeps pushing.
                    write_reg(CFG_THR, CFG_W'($urandom_range(200, 3000)));
                    write_reg(CFG_VETO, 16'd20);
                    write_reg(CFG_ACT, 16'd261);
                    send_quiet   = 1'b1;
                    hold_request = 400;
                    random_items(250);
                end
                3: begin
                    // Tightest settings: every candidate is dropped.
                    write_reg(CFG_THR, 16'hFFFF);
                    write_reg(CFG_VETO, 16'd4095);
                    write_reg(CFG_ACT, 16'd0);
                    random_items(100);
                end
                4: begin
                    write_reg(CFG_THR, 16'd0);
                    write_reg(CFG_VETO, 16'd0);
                    write_reg(CFG_ACT, 16'd261);
                    saturating_run(1'b1);
                    saturating_run(1'b0);
                    random_items(100);
                end
                default: begin
                    if (ph == 5)
                        write_reg(CFG_SPARE, CFG_W'($urandom_range(0, 65535)));
                    write_reg(CFG_THR, CFG_W'(($urandom_range(0, 3) == 0)
                                              ? 0 : $urandom_range(0, 2000)));
                    write_reg(CFG_VETO, CFG_W'($urandom_range(0, 80)));
                    write_reg(CFG_ACT, CFG_W'($urandom_range(60, 1200)));
                    random_items(250);
                end
            endcase
            wait_idle();
        end

        $display("Ran %0d items and checked %0d sum pairs over %0d register settings;",
                 items_taken, results_checked, PHASE_COUNT);
        $display("%0d candidates went to the isolation sum and %0d to the activity sum.",
                 iso_hits, act_hits);
        if (mismatches == 0 && pending_sums.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin : run_limit
        #(RUN_LIMIT_NS);
        $display("%0t: run limit reached, %0d items taken of %0d, %0d results outstanding",
                 $time, items_taken, items_queued, pending_sums.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
